[rtl/mmph_pkg.sv]
package mmph_pkg;

  // Widest mask that is tested; the hit map holds 2^MaxMaskBits slots
  localparam int unsigned MaxMaskBits = 12;
  localparam int unsigned MapDepth    = 1 << MaxMaskBits;

  // Field widths
  localparam int unsigned DataW   = 64;
  localparam int unsigned PosW    = 6;                          // bit position in a 64-bit word
  localparam int unsigned CntW    = 7;                          // set-bit count 0..64
  localparam int unsigned NW      = $clog2(MaxMaskBits + 1);    // tested count 0..MaxMaskBits
  localparam int unsigned PosIdxW = (MaxMaskBits > 1) ? $clog2(MaxMaskBits) : 1;
  localparam int unsigned SlotW   = MaxMaskBits;
  localparam int unsigned IdxW    = MaxMaskBits + 1;            // holds 2^MaxMaskBits itself

  // Queue between the scanner and the hash tester
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // Stream widths
  localparam int unsigned InTdataW  = 2 * DataW;
  localparam int unsigned OutTdataW = 8;

  // One classified item: multiplier plus the positions of the mask's set bits
  typedef struct packed {
    logic [DataW-1:0]                   mult;
    logic                               too_wide;
    logic [NW-1:0]                      nbits;
    logic [MaxMaskBits-1:0][PosW-1:0]   pos;
  } mmph_item_t;

endpackage

[rtl/magic_multiply_perfect_hash_check.sv]
// The scanner walks the mask one bit at a time; the tester marks the hit map for every subset,
// drains the multiply pipeline, checks and clears the hit map, and then emits the result.
// The scanner can take a new transaction while the tester still works on an earlier one;
// too-wide masks skip the marking and checking and go straight to the result.
// Reset: asynchronous, active low; a sweep then clears every hit map entry, with
// s_axis_tready_o held low until it completes.
module magic_multiply_perfect_hash_check (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [63:0] mask, [127:64] multiplier
  input  logic [mmph_pkg::InTdataW-1:0]    s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [0] is_perfect, [7:1] zero
  output logic [mmph_pkg::OutTdataW-1:0]   m_axis_tdata_o,
  // [0] too_wide
  output logic                             m_axis_tuser_o
);
  import mmph_pkg::*;

  mmph_item_t push_item;
  mmph_item_t head_item;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  logic       clearing;

  // Front: accept and classify
  mmph_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .hold_i          (clearing),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .full_i          (full),
    .push_o          (push),
    .item_o          (push_item)
  );

  // Queue between front and back
  mmph_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (head_item)
  );

  // Back: hash every subset and check the hit map
  mmph_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .item_i          (head_item),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

[rtl/mmph_front.sv]
module mmph_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            hold_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [63:0] mask, [127:64] multiplier
  input  logic [mmph_pkg::InTdataW-1:0]   s_axis_tdata_i,
  input  logic                            full_i,
  output logic                            push_o,
  output mmph_pkg::mmph_item_t            item_o
);
  import mmph_pkg::*;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_SCAN,
    FR_PUSH
  } front_state_e;

  front_state_e                     state_q;
  logic [DataW-1:0]                 mask_q;
  logic [DataW-1:0]                 mult_q;
  logic [PosW-1:0]                  bit_q;
  logic [CntW-1:0]                  cnt_q;
  logic [MaxMaskBits-1:0][PosW-1:0] pos_q;
  logic                             too_wide;

  assign s_axis_tready_o = (state_q == FR_IDLE) && !hold_i;
  assign push_o          = (state_q == FR_PUSH) && !full_i;

  // Classify: count set bits and record the low positions
  assign too_wide        = cnt_q > CntW'(MaxMaskBits);
  assign item_o.mult     = mult_q;
  assign item_o.too_wide = too_wide;
  assign item_o.nbits    = too_wide ? '0 : cnt_q[NW-1:0];
  assign item_o.pos      = pos_q;

  // Scanner: one mask bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      mask_q  <= '0;
      mult_q  <= '0;
      bit_q   <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else begin
      case (state_q)
        FR_IDLE: begin
          if (s_axis_tvalid_i && s_axis_tready_o) begin
            mask_q  <= s_axis_tdata_i[DataW-1:0];
            mult_q  <= s_axis_tdata_i[2*DataW-1:DataW];
            bit_q   <= '0;
            cnt_q   <= '0;
            state_q <= FR_SCAN;
          end
        end
        FR_SCAN: begin
          if (mask_q[bit_q]) begin
            if (cnt_q < CntW'(MaxMaskBits)) begin
              pos_q[cnt_q[PosIdxW-1:0]] <= bit_q;
            end
            cnt_q <= cnt_q + CntW'(1);
          end
          bit_q <= bit_q + PosW'(1);
          if (bit_q == PosW'(DataW - 1)) begin
            state_q <= FR_PUSH;
          end
        end
        FR_PUSH: begin
          if (!full_i) begin
            state_q <= FR_IDLE;
          end
        end
        default: state_q <= FR_IDLE;
      endcase
    end
  end

endmodule

[rtl/mmph_fifo.sv]
module mmph_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mmph_pkg::mmph_item_t  item_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output mmph_pkg::mmph_item_t  item_o
);
  import mmph_pkg::*;

  mmph_item_t          slots_q [FifoDepth];
  logic [FifoAw-1:0]   wr_ptr_q;
  logic [FifoAw-1:0]   rd_ptr_q;
  logic [FifoAw:0]     count_q;

  assign full_o  = count_q == (FifoAw+1)'(FifoDepth);
  assign empty_o = count_q == '0;
  assign item_o  = slots_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FifoAw'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoAw'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == FifoAw'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoAw'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (FifoAw+1)'(1);
        2'b01:   count_q <= count_q - (FifoAw+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[rtl/mmph_back.sv]
module mmph_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  mmph_pkg::mmph_item_t             item_i,
  output logic                             pop_o,
  output logic                             clearing_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [0] is_perfect, [7:1] zero
  output logic [mmph_pkg::OutTdataW-1:0]   m_axis_tdata_o,
  // [0] too_wide
  output logic                             m_axis_tuser_o
);
  import mmph_pkg::*;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MARK,
    BK_DRAIN,
    BK_CHECK,
    BK_FLUSH,
    BK_DONE
  } back_state_e;

  back_state_e                      state_q;
  logic [DataW-1:0]                 mult_q;
  logic [NW-1:0]                    n_q;
  logic [MaxMaskBits-1:0][PosW-1:0] pos_q;
  logic                             too_wide_q;
  logic [IdxW-1:0]                  idx_q;
  logic                             ok_q;
  logic                             rd_v_q;
  logic                             m_tvalid_q;
  logic                             perfect_q;
  logic                             wide_q;
  logic [IdxW-1:0]                  size_m1;

  // Multiply pipeline
  logic                             v0_q, v1_q, v2_q, v3_q;
  logic [DataW-1:0]                 subset_q;
  logic [DataW-1:0]                 acc1_q, acc2_q, acc3_q;
  logic [DataW/2-1:0]               hi1_q, hi2_q;
  logic [DataW/2-1:0]               lo1_q;
  logic [DataW-1:0]                 subset_d;
  logic [DataW-1:0]                 p0;
  logic [DataW/2-1:0]               p1, p2;
  logic [SlotW-1:0]                 top_bits;
  logic [SlotW-1:0]                 slot;

  // Hit map
  logic                             slot_map_q [MapDepth];
  logic                             rd_bit_q;
  logic                             wr_en;
  logic [SlotW-1:0]                 wr_addr;
  logic                             wr_data;
  logic                             rd_en;

  assign size_m1         = (IdxW'(1) << n_q) - IdxW'(1);
  assign clearing_o      = state_q == BK_CLEAR;
  assign pop_o           = (state_q == BK_IDLE) && !empty_i;
  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = {{(OutTdataW-1){1'b0}}, perfect_q};
  assign m_axis_tuser_o  = wide_q;

  // Deposit the index bits into the recorded set-bit positions
  always_comb begin
    subset_d = '0;
    for (int unsigned j = 0; j < MaxMaskBits; j++) begin
      if (idx_q[j] && (j < n_q)) begin
        subset_d = subset_d | (DataW'(1) << pos_q[j]);
      end
    end
  end

  // Low 64 bits of subset * mult from three 32x32 partial products
  assign p0 = subset_q[DataW/2-1:0] * mult_q[DataW/2-1:0];
  assign p1 = lo1_q * mult_q[DataW-1:DataW/2];
  assign p2 = hi2_q * mult_q[DataW/2-1:0];

  // Slot is the top n bits of the product; n = 0 gives slot 0
  assign top_bits = acc3_q[DataW-1 -: SlotW];
  assign slot     = top_bits >> (NW'(MaxMaskBits) - n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= state_q == BK_MARK;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    subset_q <= subset_d;
    acc1_q   <= p0;
    lo1_q    <= subset_q[DataW/2-1:0];
    hi1_q    <= subset_q[DataW-1:DataW/2];
    acc2_q   <= {acc1_q[DataW-1:DataW/2] + p1, acc1_q[DataW/2-1:0]};
    hi2_q    <= hi1_q;
    acc3_q   <= {acc2_q[DataW-1:DataW/2] + p2, acc2_q[DataW/2-1:0]};
  end

  // Hit map port: clear sweep, mark, or read-and-clear during the check
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q[SlotW-1:0];
    wr_data = 1'b0;
    rd_en   = 1'b0;
    case (state_q)
      BK_CLEAR: wr_en = 1'b1;
      BK_CHECK: begin
        wr_en = 1'b1;
        rd_en = 1'b1;
      end
      default: begin
        if (v3_q) begin
          wr_en   = 1'b1;
          wr_addr = slot;
          wr_data = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_map_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_bit_q <= slot_map_q[idx_q[SlotW-1:0]];
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_CLEAR;
      idx_q      <= '0;
      mult_q     <= '0;
      n_q        <= '0;
      pos_q      <= '0;
      too_wide_q <= 1'b0;
      ok_q       <= 1'b0;
      rd_v_q     <= 1'b0;
      m_tvalid_q <= 1'b0;
      perfect_q  <= 1'b0;
      wide_q     <= 1'b0;
    end else begin
      rd_v_q <= rd_en;
      if (rd_v_q) begin
        ok_q <= ok_q & rd_bit_q;
      end
      // Result taken; a new one loaded in BK_DONE takes precedence
      if (m_tvalid_q && m_axis_tready_i && (state_q != BK_DONE)) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        BK_CLEAR: begin
          if (idx_q == IdxW'(MapDepth - 1)) begin
            idx_q   <= '0;
            state_q <= BK_IDLE;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        BK_IDLE: begin
          if (!empty_i) begin
            mult_q     <= item_i.mult;
            n_q        <= item_i.nbits;
            pos_q      <= item_i.pos;
            too_wide_q <= item_i.too_wide;
            ok_q       <= 1'b1;
            idx_q      <= '0;
            state_q    <= item_i.too_wide ? BK_DONE : BK_MARK;
          end
        end
        BK_MARK: begin
          idx_q <= idx_q + IdxW'(1);
          if (idx_q == size_m1) begin
            state_q <= BK_DRAIN;
          end
        end
        BK_DRAIN: begin
          idx_q <= '0;
          if (!(v0_q || v1_q || v2_q || v3_q)) begin
            state_q <= BK_CHECK;
          end
        end
        BK_CHECK: begin
          idx_q <= idx_q + IdxW'(1);
          if (idx_q == size_m1) begin
            state_q <= BK_FLUSH;
          end
        end
        BK_FLUSH: state_q <= BK_DONE;
        BK_DONE: begin
          if (!m_tvalid_q || m_axis_tready_i) begin
            m_tvalid_q <= 1'b1;
            perfect_q  <= ok_q && !too_wide_q;
            wide_q     <= too_wide_q;
            state_q    <= BK_IDLE;
          end
        end
        default: state_q <= BK_IDLE;
      endcase
    end
  end

  // A mark write never lands outside the mark phase
  a_mark_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (state_q == BK_MARK || state_q == BK_DRAIN))
    else $error("hit map marked outside the mark phase");

  // Index stays within the table of the current item while marking or checking
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_MARK || state_q == BK_CHECK) |-> idx_q <= size_m1)
    else $error("subset index beyond table size");

  // A too-wide result never reports a perfect hash
  a_wide_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && wide_q) |-> !perfect_q)
    else $error("too-wide mask reported as perfect");

  // An item is taken from the queue only once the clear sweep is done
  a_pop_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !clearing_o)
    else $error("item taken during clear sweep");

endmodule

[verif/magic_multiply_perfect_hash_check_tb.sv]
`timescale 1ns / 1ps

module magic_multiply_perfect_hash_check_tb;
  import mmph_pkg::*;

  localparam int unsigned LongHoldCycles = 600;
  localparam int unsigned TailCycles     = 200;
  localparam longint unsigned RunLimitNs = 64'd60_000_000;

  typedef struct {
    logic [DataW-1:0] mask;
    logic [DataW-1:0] mult;
  } hash_job_t;

  typedef struct {
    logic is_perfect;
    logic too_wide;
  } hash_verdict_t;

  typedef enum int {
    PhDirected,
    PhFreeFlow,
    PhBackpressure,
    PhSendIdle,
    PhRecvStall,
    PhBothIdle
  } run_phase_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic                 m_axis_tuser_o;

  hash_job_t     job_q[$];
  hash_verdict_t verdict_q[$];
  run_phase_e    phase;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  int unsigned   queued_cnt;
  int unsigned   accepted_cnt;
  int unsigned   result_cnt;
  int unsigned   err_cnt;
  logic          in_taken;
  logic          rx_hold;

  magic_multiply_perfect_hash_check uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // 100 MHz clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hash every subset of the mask and check that the slots cover the whole table
  function automatic hash_verdict_t predict_verdict(logic [DataW-1:0] mask,
                                                    logic [DataW-1:0] mult);
    hash_verdict_t        v;
    bit [MapDepth-1:0]    hit_map;
    logic [DataW-1:0]     subset;
    logic [DataW-1:0]     prod;
    int unsigned          nbits;
    int unsigned          idx;
    int unsigned          pos;
    int unsigned          j;
    int unsigned          slot;
    nbits        = $countones(mask);
    v.too_wide   = 1'b0;
    v.is_perfect = 1'b1;
    if (nbits > MaxMaskBits) begin
      v.too_wide   = 1'b1;
      v.is_perfect = 1'b0;
      return v;
    end
    hit_map = '0;
    for (idx = 0; idx < (32'd1 << nbits); idx++) begin
      // deposit index bits into the set-bit positions, lowest first
      subset = '0;
      j      = 0;
      for (pos = 0; pos < DataW; pos++) begin
        if (mask[pos]) begin
          subset[pos] = idx[j];
          j++;
        end
      end
      prod = subset * mult;  // low 64 bits only
      slot = (nbits == 0) ? 0 : int'(prod >> (DataW - nbits));
      hit_map[slot] = 1'b1;
    end
    for (idx = 0; idx < (32'd1 << nbits); idx++) begin
      if (!hit_map[idx]) v.is_perfect = 1'b0;
    end
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic add_job(logic [DataW-1:0] mask, logic [DataW-1:0] mult);
    hash_job_t job;
    job.mask = mask;
    job.mult = mult;
    job_q.push_back(job);
    queued_cnt++;
  endtask

  function automatic logic [DataW-1:0] mask_with_bits(int unsigned k);
    logic [DataW-1:0] m;
    m = '0;
    while ($countones(m) < k) m[$urandom_range(DataW - 1)] = 1'b1;
    return m;
  endfunction

  function automatic logic [DataW-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed masks with small set-bit counts; some constructed
  // perfect hashes, a few wide or too-wide masks.
  task automatic add_random_job();
    int unsigned      sel;
    int unsigned      k;
    int unsigned      p;
    logic [DataW-1:0] mask;
    logic [DataW-1:0] mult;
    sel = $urandom_range(99);
    if (sel < 10) begin
      mask = ($urandom_range(1) == 0) ? random_word() : mask_with_bits($urandom_range(13, 64));
      if ($countones(mask) <= MaxMaskBits) mask = ~mask;
      add_job(mask, random_word());
    end else if (sel < 15) begin
      k = ($urandom_range(3) == 0) ? MaxMaskBits : $urandom_range(10, MaxMaskBits - 1);
      add_job(mask_with_bits(k), random_word());
    end else if (sel < 45) begin
      // contiguous window times a power of two maps subsets straight onto slots;
      // junk above bit 64-p is multiplied out of the product
      k    = $urandom_range(0, 9);
      p    = $urandom_range(0, DataW - k);
      mask = ((64'd1 << k) - 64'd1) << p;
      mult = 64'd1 << (DataW - k - p);
      if (p > 0 && p < DataW) mult = mult | (random_word() << (DataW - p));
      add_job(mask, mult);
    end else begin
      k    = $urandom_range(0, 9);
      mult = ($urandom_range(1) == 0) ? random_word() : (random_word() & random_word());
      add_job(mask_with_bits(k), mult);
    end
  endtask

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || result_cnt != accepted_cnt) @(negedge clk_i);
  endtask

  // Input driver: offer a new transaction once the previous one was taken
  always @(negedge clk_i) begin
    if (!s_axis_tvalid_i || in_taken) begin
      in_taken = 1'b0;
      if (job_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {job_q[0].mult, job_q[0].mask};
        void'(job_q.pop_front());
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Output ready: random stalls, or held low during the long hold-off
  always @(negedge clk_i) begin
    if (rx_hold) m_axis_tready_i <= 1'b0;
    else         m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off, counted here while the sender keeps offering
  initial begin
    rx_hold = 1'b0;
    wait (phase == PhBackpressure);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (LongHoldCycles) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // Monitor: predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    hash_verdict_t want;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      verdict_q.push_back(predict_verdict(s_axis_tdata_i[DataW-1:0],
                                          s_axis_tdata_i[2*DataW-1:DataW]));
      accepted_cnt++;
      in_taken = 1'b1;
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      result_cnt++;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result with no transaction pending: tdata=%0h tuser=%0b",
                                  m_axis_tdata_o, m_axis_tuser_o));
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata_o !== {{(OutTdataW-1){1'b0}}, want.is_perfect})
          report_mismatch($sformatf("result %0d: tdata=%0h, is_perfect expected %0b",
                                    result_cnt, m_axis_tdata_o, want.is_perfect));
        if (m_axis_tuser_o !== want.too_wide)
          report_mismatch($sformatf("result %0d: too_wide=%0b, expected %0b",
                                    result_cnt, m_axis_tuser_o, want.too_wide));
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned i;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    in_taken        = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    queued_cnt      = 0;
    accepted_cnt    = 0;
    result_cnt      = 0;
    err_cnt         = 0;
    phase           = PhDirected;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty mask, too-wide masks, widest tested mask, wrap, extremes
    add_job(64'h0, 64'h0);
    add_job(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_job(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_job(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    add_job(64'h0000_0000_0000_1FFF, 64'h0008_0000_0000_0000);
    add_job(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    add_job(64'h0000_0000_0000_0FFF, 64'h0010_0000_0000_0000);
    add_job(64'hFFF0_0000_0000_0000, 64'h0000_0000_0000_0001);
    add_job(64'h0000_0000_0000_0FFF, 64'h0);
    add_job(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    add_job(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
    add_job(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001);
    add_job(64'hC000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    add_job(64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF);
    add_job(64'h8102_0408_1020_4081, 64'h0204_0810_2040_8100);
    add_job(mask_with_bits(11), random_word());
    add_job(mask_with_bits(MaxMaskBits), random_word());
    wait_drained();

    phase = PhFreeFlow;
    for (i = 0; i < 22; i++) add_random_job();
    wait_drained();

    // Sender keeps offering while the receiver is held off
    phase = PhBackpressure;
    for (i = 0; i < 10; i++) add_job(mask_with_bits($urandom_range(0, 4)), random_word());
    wait_drained();

    phase         = PhSendIdle;
    send_idle_pct = 63;
    for (i = 0; i < 23; i++) add_random_job();
    wait_drained();

    phase          = PhRecvStall;
    send_idle_pct  = 0;
    recv_stall_pct = 63;
    for (i = 0; i < 23; i++) add_random_job();
    wait_drained();

    phase          = PhBothIdle;
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    for (i = 0; i < 22; i++) add_random_job();
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("** magic_multiply_perfect_hash_check: PASSED **");
    end else begin
      $display("** magic_multiply_perfect_hash_check: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RunLimitNs);
    $display("[%0t] timeout: %0d queued, %0d accepted, %0d results",
             $time, queued_cnt, accepted_cnt, result_cnt);
    $display("** magic_multiply_perfect_hash_check: FAILED **");
    $finish;
  end

endmodule

[files.f]
rtl/mmph_pkg.sv
rtl/mmph_front.sv
rtl/mmph_fifo.sv
rtl/mmph_back.sv
rtl/magic_multiply_perfect_hash_check.sv
verif/magic_multiply_perfect_hash_check_tb.sv
